[src/touch_tap_swipe_classifier_assert.svh]
// Assertion macros for the touch classifier RTL.
`ifndef TOUCH_TAP_SWIPE_CLASSIFIER_ASSERT_SVH
`define TOUCH_TAP_SWIPE_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define TTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("touch classifier: same-cycle check failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define TTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("touch classifier: next-cycle check failed");

`endif

[src/tts_pkg.sv]
// Types, constants and helper functions for the touch tap and swipe classifier.
`default_nettype none
package tts_pkg;

  localparam int COORD_W     = 12;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 56;

  // Count register low nibble that means exactly one finger on the panel.
  localparam logic [3:0] TOUCH_ONE = 4'd1;

  localparam logic [11:0] SWIPE_MIN_RST = 12'd60;
  localparam logic [11:0] TAP_MAX_RST   = 12'd25;
  localparam logic [12:0] CANVAS_W_RST  = 13'd240;
  localparam logic [12:0] CANVAS_H_RST  = 13'd280;

  // Two's complement swipe codes.
  localparam logic [1:0] SWIPE_NONE  = 2'b00;
  localparam logic [1:0] SWIPE_RIGHT = 2'b01;
  localparam logic [1:0] SWIPE_LEFT  = 2'b11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SWIPE_MIN = 2'd0,
    REG_TAP_MAX   = 2'd1,
    REG_CANVAS_W  = 2'd2,
    REG_CANVAS_H  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0] swipe_min;
    logic [11:0] tap_max;
    logic [12:0] width_px;
    logic [12:0] height_px;
  } cfg_t;

  typedef struct packed {
    logic       read_ok;
    logic       hold_off;
    logic [7:0] count_byte;
    logic [7:0] x_high_byte;
    logic [7:0] x_low_byte;
    logic [7:0] y_high_byte;
    logic [7:0] y_low_byte;
  } frame_t;

  typedef struct packed {
    logic               pressed;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] latest_x;
    logic [COORD_W-1:0] latest_y;
    logic [COORD_W-1:0] tap_x;
    logic [COORD_W-1:0] tap_y;
    logic [COORD_W-1:0] raw_x;
    logic [COORD_W-1:0] raw_y;
  } trk_t;

  typedef struct packed {
    logic               finger_down;
    logic               tap_event;
    logic [1:0]         swipe_dir;
    logic [COORD_W-1:0] tap_pos_x;
    logic [COORD_W-1:0] tap_pos_y;
    logic [COORD_W-1:0] raw_pos_x;
    logic [COORD_W-1:0] raw_pos_y;
  } result_t;

  // Clamp a coordinate to size - 1; a zero size behaves as a size of one.
  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v,
                                                     input logic [12:0] size);
    logic [12:0] lim;
    lim = (size == 13'd0) ? 13'd0 : size - 13'd1;
    return ({1'b0, v} > lim) ? lim[COORD_W-1:0] : v;
  endfunction

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

endpackage
`default_nettype wire

[src/tts_cfg_regs.sv]
// Configuration register file for the touch classifier thresholds and canvas size.
`default_nettype none
module tts_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         wr_en,
  input  wire logic [tts_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [tts_pkg::CFG_DATA_W-1:0] wr_data,
  output tts_pkg::cfg_t                     cfg
);
  import tts_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_SWIPE_MIN: cfg_nxt.swipe_min = wr_data[11:0];
        REG_TAP_MAX:   cfg_nxt.tap_max   = wr_data[11:0];
        REG_CANVAS_W:  cfg_nxt.width_px  = wr_data;
        REG_CANVAS_H:  cfg_nxt.height_px = wr_data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swipe_min <= SWIPE_MIN_RST;
      cfg_r.tap_max   <= TAP_MAX_RST;
      cfg_r.width_px  <= CANVAS_W_RST;
      cfg_r.height_px <= CANVAS_H_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[src/tts_classify.sv]
// Per-frame press tracking and release classification, purely combinational.
`default_nettype none
module tts_classify (
  input  wire tts_pkg::frame_t  frame,
  input  wire tts_pkg::trk_t    trk,
  input  wire tts_pkg::cfg_t    cfg,
  output tts_pkg::trk_t         trk_nxt,
  output tts_pkg::result_t      res
);
  import tts_pkg::*;

  logic [COORD_W-1:0] raw_x;
  logic [COORD_W-1:0] raw_y;
  logic [COORD_W-1:0] clp_x;
  logic [COORD_W-1:0] clp_y;
  logic [COORD_W-1:0] adx;
  logic [COORD_W-1:0] ady;
  logic               touching;
  logic               is_swipe;
  logic               is_tap;
  logic               tap;
  logic [1:0]         swipe;

  assign raw_x    = {frame.x_high_byte[3:0], frame.x_low_byte};
  assign raw_y    = {frame.y_high_byte[3:0], frame.y_low_byte};
  assign clp_x    = clamp_coord(raw_x, cfg.width_px);
  assign clp_y    = clamp_coord(raw_y, cfg.height_px);
  assign touching = frame.read_ok && (frame.count_byte[3:0] == TOUCH_ONE);

  assign adx      = abs_diff(trk.latest_x, trk.start_x);
  assign ady      = abs_diff(trk.latest_y, trk.start_y);
  assign is_swipe = (adx >= cfg.swipe_min) && (adx > ady);
  assign is_tap   = (adx < cfg.tap_max) && (ady < cfg.tap_max);

  always_comb begin
    trk_nxt = trk;
    tap     = 1'b0;
    swipe   = SWIPE_NONE;
    if (frame.hold_off) begin
      trk_nxt.pressed = 1'b0;
    end else if (touching) begin
      trk_nxt.raw_x    = raw_x;
      trk_nxt.raw_y    = raw_y;
      trk_nxt.latest_x = clp_x;
      trk_nxt.latest_y = clp_y;
      if (!trk.pressed) begin
        trk_nxt.pressed = 1'b1;
        trk_nxt.start_x = clp_x;
        trk_nxt.start_y = clp_y;
      end
    end else if (trk.pressed) begin
      trk_nxt.pressed = 1'b0;
      if (is_swipe) begin
        swipe = (trk.latest_x > trk.start_x) ? SWIPE_RIGHT : SWIPE_LEFT;
      end else if (is_tap) begin
        tap           = 1'b1;
        trk_nxt.tap_x = trk.latest_x;
        trk_nxt.tap_y = trk.latest_y;
      end
    end
  end

  always_comb begin
    res.finger_down = trk_nxt.pressed;
    res.tap_event   = tap;
    res.swipe_dir   = swipe;
    res.tap_pos_x   = trk_nxt.tap_x;
    res.tap_pos_y   = trk_nxt.tap_y;
    res.raw_pos_x   = trk_nxt.raw_x;
    res.raw_pos_y   = trk_nxt.raw_y;
  end

endmodule
`default_nettype wire

[src/touch_tap_swipe_classifier.sv]
// Top level of the touch tap and swipe classifier.
//
// Usage: each transaction on the in_ channel carries one poll frame of a
// single-touch controller; each frame yields exactly one transaction on the
// out_ channel, in order. The result gives whether a press is tracked, a tap
// or swipe event for this frame, the held tap point and the latest raw point.
// The frame sits in the input register, then the classifier logic feeds the result
// register, and out_tvalid rises once that result register is loaded.
// Throughput is one frame per cycle while out_tready stays high; the press state
// updates in the same cycle as the result register, so consecutive frames need no gap.
// The cfg_ channel writes thresholds and canvas size, always ready; writes
// should be made while no frame is in flight.
// Reset (rst_n low, synchronous) empties both registers, clears the press
// state and held points, and restores the default register values.
// When the receiver holds out_tready low the result stays put, the input
// register still takes one more frame, and in_tready then falls until the
// result is taken.
`default_nettype none
module touch_tap_swipe_classifier (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  // [7:0] count_byte, [15:8] x_high_byte, [23:16] x_low_byte,
  // [31:24] y_high_byte, [39:32] y_low_byte
  input  wire logic [tts_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] read_ok, [1] hold_off
  input  wire logic [tts_pkg::IN_TUSER_W-1:0]    in_tuser,
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  // [0] finger_down, [1] tap_event, [3:2] swipe_dir (signed), [15:4] tap_pos_x,
  // [27:16] tap_pos_y, [39:28] raw_pos_x, [51:40] raw_pos_y, [55:52] zero
  output      logic [tts_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [tts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tts_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tts_pkg::*;

  cfg_t    cfg;
  frame_t  frm_r;
  frame_t  frm_nxt;
  logic    frm_vld_r;
  logic    frm_vld_nxt;
  logic    out_vld_r;
  logic    out_vld_nxt;
  trk_t    trk_r;
  trk_t    trk_nxt;
  trk_t    trk_calc;
  result_t res_r;
  result_t res_nxt;
  result_t res_calc;
  logic    in_acc;
  logic    adv;
  logic    fire;
  logic    out_evt;

  assign cfg_ready = 1'b1;

  tts_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tts_classify u_classify (
    .frame   (frm_r),
    .trk     (trk_r),
    .cfg     (cfg),
    .trk_nxt (trk_calc),
    .res     (res_calc)
  );

  // The result register is free when empty or being taken this cycle.
  assign adv       = !out_vld_r || out_tready;
  assign fire      = frm_vld_r && adv;
  assign in_tready = !frm_vld_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    frm_nxt = frm_r;
    if (in_acc) begin
      frm_nxt.read_ok     = in_tuser[0];
      frm_nxt.hold_off    = in_tuser[1];
      frm_nxt.count_byte  = in_tdata[7:0];
      frm_nxt.x_high_byte = in_tdata[15:8];
      frm_nxt.x_low_byte  = in_tdata[23:16];
      frm_nxt.y_high_byte = in_tdata[31:24];
      frm_nxt.y_low_byte  = in_tdata[39:32];
    end
    frm_vld_nxt = in_acc || (frm_vld_r && !adv);
    out_vld_nxt = fire || (out_vld_r && !out_tready);
    trk_nxt     = fire ? trk_calc : trk_r;
    res_nxt     = fire ? res_calc : res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frm_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      trk_r     <= '0;
    end else begin
      frm_vld_r <= frm_vld_nxt;
      out_vld_r <= out_vld_nxt;
      trk_r     <= trk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frm_r <= frm_nxt;
    res_r <= res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, res_r.raw_pos_y, res_r.raw_pos_x, res_r.tap_pos_y,
                       res_r.tap_pos_x, res_r.swipe_dir, res_r.tap_event,
                       res_r.finger_down};

  assign out_evt = res_r.tap_event || (res_r.swipe_dir != SWIPE_NONE);

`include "touch_tap_swipe_classifier_assert.svh"

  // A tap or swipe is only ever reported on a release.
  `TTS_ASSERT_IMP(a_event_is_release, out_vld_r && out_evt, !res_r.finger_down)
  `TTS_ASSERT_IMP(a_tap_not_swipe, out_vld_r && res_r.tap_event, res_r.swipe_dir == SWIPE_NONE)
  `TTS_ASSERT_IMP(a_swipe_code, out_vld_r, res_r.swipe_dir != 2'b10)
  // The press state only moves together with a new result, so they agree.
  `TTS_ASSERT_IMP(a_press_matches, out_vld_r, res_r.finger_down == trk_r.pressed)
  `TTS_ASSERT_NXT(a_fire_loads_out, fire, out_vld_r)

endmodule
`default_nettype wire

[sim/touch_tap_swipe_classifier_tb.sv]
// Self-checking testbench for the touch tap and swipe classifier stream block.
`timescale 1ns / 1ps
module touch_tap_swipe_classifier_tb;
  import tts_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned RANDOM_PHASES = 5;

  typedef enum int unsigned {
    LIFT_COUNT,
    LIFT_READ_FAIL,
    LIFT_HOLD_OFF
  } lift_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  // Mirror of the gesture tracker and its settings.
  cfg_t        gest_cfg;
  trk_t        gest_trk;
  result_t     expected_results[$];

  int unsigned mismatch_count  = 0;
  int unsigned cycle_count     = 0;
  int unsigned frames_sent     = 0;
  int unsigned hold_cycles_req = 0;
  bit          src_quiet       = 1'b0;
  bit          sink_quiet      = 1'b0;
  bit          no_src_gap      = 1'b0;

  touch_tap_swipe_classifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [COORD_W-1:0] fit_to_canvas(logic [COORD_W-1:0] v,
                                                       logic [12:0] size);
    if (size == 13'd0) return '0;
    if (size > {1'b0, v}) return v;
    return 12'(size - 13'd1);
  endfunction

  // Advances the tracker mirror by one poll frame and returns its result.
  function automatic result_t classify_frame(frame_t f);
    result_t             r;
    logic [COORD_W-1:0]  rx, ry, cx, cy, adx, ady;
    r = '0;
    if (f.hold_off) begin
      gest_trk.pressed = 1'b0;
    end else if (f.read_ok && f.count_byte[3:0] == TOUCH_ONE) begin
      rx = {f.x_high_byte[3:0], f.x_low_byte};
      ry = {f.y_high_byte[3:0], f.y_low_byte};
      cx = fit_to_canvas(rx, gest_cfg.width_px);
      cy = fit_to_canvas(ry, gest_cfg.height_px);
      gest_trk.raw_x = rx;
      gest_trk.raw_y = ry;
      if (!gest_trk.pressed) begin
        gest_trk.pressed = 1'b1;
        gest_trk.start_x = cx;
        gest_trk.start_y = cy;
      end
      gest_trk.latest_x = cx;
      gest_trk.latest_y = cy;
    end else if (gest_trk.pressed) begin
      adx = (gest_trk.latest_x >= gest_trk.start_x) ? gest_trk.latest_x - gest_trk.start_x
                                                     : gest_trk.start_x - gest_trk.latest_x;
      ady = (gest_trk.latest_y >= gest_trk.start_y) ? gest_trk.latest_y - gest_trk.start_y
                                                     : gest_trk.start_y - gest_trk.latest_y;
      gest_trk.pressed = 1'b0;
      if (adx >= gest_cfg.swipe_min && adx > ady) begin
        r.swipe_dir = (gest_trk.latest_x > gest_trk.start_x) ? SWIPE_RIGHT : SWIPE_LEFT;
      end else if (adx < gest_cfg.tap_max && ady < gest_cfg.tap_max) begin
        r.tap_event    = 1'b1;
        gest_trk.tap_x = gest_trk.latest_x;
        gest_trk.tap_y = gest_trk.latest_y;
      end
    end
    r.finger_down = gest_trk.pressed;
    r.tap_pos_x   = gest_trk.tap_x;
    r.tap_pos_y   = gest_trk.tap_y;
    r.raw_pos_x   = gest_trk.raw_x;
    r.raw_pos_y   = gest_trk.raw_y;
    return r;
  endfunction

  function automatic void check_field(string label, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
      mismatch_count++;
    end
  endfunction

  // Predicts on every accepted frame and checks every accepted result.
  always @(posedge clk) begin
    frame_t  f;
    result_t got;
    result_t want;
    if (!rst_n) begin
      gest_cfg.swipe_min = SWIPE_MIN_RST;
      gest_cfg.tap_max   = TAP_MAX_RST;
      gest_cfg.width_px  = CANVAS_W_RST;
      gest_cfg.height_px = CANVAS_H_RST;
      gest_trk           = '0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.finger_down = out_tdata[0];
        got.tap_event   = out_tdata[1];
        got.swipe_dir   = out_tdata[3:2];
        got.tap_pos_x   = out_tdata[15:4];
        got.tap_pos_y   = out_tdata[27:16];
        got.raw_pos_x   = out_tdata[39:28];
        got.raw_pos_y   = out_tdata[51:40];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction: expected none, actual %h",
                   $time, out_tdata);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("finger_down", want.finger_down, got.finger_down);
          check_field("tap_event", want.tap_event, got.tap_event);
          check_field("swipe_dir", want.swipe_dir, got.swipe_dir);
          check_field("tap_pos_x", want.tap_pos_x, got.tap_pos_x);
          check_field("tap_pos_y", want.tap_pos_y, got.tap_pos_y);
          check_field("raw_pos_x", want.raw_pos_x, got.raw_pos_x);
          check_field("raw_pos_y", want.raw_pos_y, got.raw_pos_y);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SWIPE_MIN: gest_cfg.swipe_min = cfg_data[11:0];
          REG_TAP_MAX:   gest_cfg.tap_max   = cfg_data[11:0];
          REG_CANVAS_W:  gest_cfg.width_px  = cfg_data;
          REG_CANVAS_H:  gest_cfg.height_px = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        f.read_ok     = in_tuser[0];
        f.hold_off    = in_tuser[1];
        f.count_byte  = in_tdata[7:0];
        f.x_high_byte = in_tdata[15:8];
        f.x_low_byte  = in_tdata[23:16];
        f.y_high_byte = in_tdata[31:24];
        f.y_low_byte  = in_tdata[39:32];
        expected_results.push_back(classify_frame(f));
      end
    end
  end

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls, or one long hold-off when a test asks for it.
  initial begin : result_sink
    int unsigned stall;
    forever begin
      @(negedge clk);
      if (hold_cycles_req != 0) begin
        stall = hold_cycles_req;
        hold_cycles_req = 0;
      end else begin
        stall = sink_quiet ? 0 : idle_length();
      end
      if (stall == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  task automatic send_frame(input frame_t f);
    int unsigned gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {f.y_low_byte, f.y_high_byte, f.x_low_byte, f.x_high_byte, f.count_byte};
    in_tuser  <= {f.hold_off, f.read_ok};
    do @(posedge clk); while (!in_tready);
    frames_sent++;
    gap = (src_quiet || no_src_gap) ? 0 : idle_length();
    if (gap != 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // The sender goes quiet first so that no frame is offered while draining.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // A single-finger frame at the given point, with junk in the ignored nibbles.
  function automatic frame_t touch_at(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    frame_t f;
    f.read_ok     = 1'b1;
    f.hold_off    = 1'b0;
    f.count_byte  = {4'($urandom), TOUCH_ONE};
    f.x_high_byte = {4'($urandom), x[11:8]};
    f.x_low_byte  = x[7:0];
    f.y_high_byte = {4'($urandom), y[11:8]};
    f.y_low_byte  = y[7:0];
    return f;
  endfunction

  function automatic frame_t noise_frame();
    logic [63:0] bits;
    frame_t      f;
    bits = {$urandom, $urandom};
    f = bits[$bits(frame_t)-1:0];
    f.hold_off = ($urandom_range(0, 7) == 0);
    return f;
  endfunction

  function automatic frame_t lift_frame(lift_t how);
    frame_t f;
    f = noise_frame();
    f.hold_off = (how == LIFT_HOLD_OFF);
    case (how)
      LIFT_COUNT: begin
        f.read_ok = 1'b1;
        if (f.count_byte[3:0] == TOUCH_ONE) f.count_byte[3:0] = 4'h0;
      end
      LIFT_READ_FAIL: f.read_ok = 1'b0;
      default: ;
    endcase
    return f;
  endfunction

  // Press, drag and lift, with the travel aimed near the current thresholds.
  task automatic random_gesture();
    logic [COORD_W-1:0] sx, sy;
    int                 dx, dy;
    int unsigned        pick;
    lift_t              lift;
    sx = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 320));
    sy = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 320));
    case ($urandom_range(0, 3))
      0: begin
        dx = $urandom_range(0, int'(gest_cfg.tap_max) + 2);
        dy = $urandom_range(0, int'(gest_cfg.tap_max) + 2);
      end
      1: begin
        dx = int'(gest_cfg.swipe_min) + int'($urandom_range(0, 40)) - 2;
        dy = $urandom_range(0, 30);
      end
      2: begin
        dx = $urandom_range(0, 60);
        dy = $urandom_range(40, 200);
      end
      default: begin
        dx = $urandom_range(0, 400);
        dy = $urandom_range(0, 400);
      end
    endcase
    if ($urandom_range(0, 1) == 1) dx = -dx;
    if ($urandom_range(0, 1) == 1) dy = -dy;
    send_frame(touch_at(sx, sy));
    repeat ($urandom_range(0, 4))
      send_frame(touch_at(12'(int'(sx) + int'($urandom_range(0, 40)) - 20),
                          12'(int'(sy) + int'($urandom_range(0, 40)) - 20)));
    send_frame(touch_at(12'(int'(sx) + dx), 12'(int'(sy) + dy)));
    pick = $urandom_range(0, 9);
    lift = (pick < 5) ? LIFT_COUNT : (pick < 8) ? LIFT_READ_FAIL : LIFT_HOLD_OFF;
    send_frame(lift_frame(lift));
  endtask

  // Hand-picked gestures under the reset settings.
  task automatic test_directed_gestures();
    frame_t f;
    // Exactly the swipe distance to the right, released by a count other than one.
    send_frame(touch_at(12'd100, 12'd100));
    send_frame(touch_at(12'd160, 12'd105));
    send_frame(lift_frame(LIFT_COUNT));
    // Leftward drag, released by a failed read.
    send_frame(touch_at(12'd200, 12'd50));
    send_frame(touch_at(12'd110, 12'd60));
    send_frame(lift_frame(LIFT_READ_FAIL));
    // Small wobble is a tap at the last point.
    send_frame(touch_at(12'd50, 12'd50));
    send_frame(touch_at(12'd60, 12'd55));
    send_frame(lift_frame(LIFT_COUNT));
    // Travel equal to the tap limit: neither tap nor swipe.
    send_frame(touch_at(12'd100, 12'd100));
    send_frame(touch_at(12'd125, 12'd100));
    send_frame(lift_frame(LIFT_COUNT));
    // Mostly vertical drag gives no event.
    send_frame(touch_at(12'd10, 12'd10));
    send_frame(touch_at(12'd10, 12'd100));
    send_frame(lift_frame(LIFT_COUNT));
    // Hold-off drops the press; its bytes are ignored even if they look like a touch.
    send_frame(touch_at(12'd30, 12'd30));
    f = touch_at(12'd900, 12'd900);
    f.hold_off = 1'b1;
    send_frame(f);
    send_frame(lift_frame(LIFT_COUNT));
    // Full-scale and zero coordinates, then an all-ones frame that is not a touch.
    send_frame(touch_at(12'hFFF, 12'hFFF));
    send_frame(touch_at(12'h000, 12'h000));
    f = '1;
    send_frame(f);
    f = '0;
    send_frame(f);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    // Zero canvas pins every point to the origin.
    write_reg(REG_CANVAS_W, 13'd0);
    write_reg(REG_CANVAS_H, 13'd0);
    write_reg(REG_SWIPE_MIN, 13'h1FFF);
    write_reg(REG_TAP_MAX, 13'd4095);
    repeat (3) random_gesture();
    wait_idle();
    // Oversized canvas leaves the full 12-bit range.
    write_reg(REG_CANVAS_W, 13'h1FFF);
    write_reg(REG_CANVAS_H, 13'd4096);
    write_reg(REG_SWIPE_MIN, 13'd0);
    write_reg(REG_TAP_MAX, 13'd0);
    repeat (4) random_gesture();
    wait_idle();
    write_reg(REG_CANVAS_W, 13'd1);
    write_reg(REG_CANVAS_H, 13'd1);
    write_reg(REG_SWIPE_MIN, 13'd4095);
    write_reg(REG_TAP_MAX, 13'd1);
    repeat (3) random_gesture();
  endtask

  // The receiver stops for a long stretch while frames keep coming.
  task automatic test_backpressure();
    wait_idle();
    write_reg(REG_SWIPE_MIN, {1'b0, SWIPE_MIN_RST});
    write_reg(REG_TAP_MAX, {1'b0, TAP_MAX_RST});
    write_reg(REG_CANVAS_W, CANVAS_W_RST);
    write_reg(REG_CANVAS_H, CANVAS_H_RST);
    hold_cycles_req = 60;
    no_src_gap = 1'b1;
    repeat (6) random_gesture();
    no_src_gap = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      write_reg(REG_SWIPE_MIN, 13'($urandom_range(10, 120)));
      write_reg(REG_TAP_MAX, 13'($urandom_range(2, 60)));
      if (phase == RANDOM_PHASES - 1) begin
        write_reg(REG_CANVAS_W, 13'd4096);
        write_reg(REG_CANVAS_H, 13'd8191);
      end else begin
        write_reg(REG_CANVAS_W, 13'($urandom_range(1, 500)));
        write_reg(REG_CANVAS_H, 13'($urandom_range(1, 500)));
      end
      // One phase runs flat out on both sides.
      src_quiet  = (phase == 2);
      sink_quiet = (phase == 2);
      target = frames_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (frames_sent < target) begin
        if ($urandom_range(0, 5) == 0) send_frame(noise_frame());
        else random_gesture();
      end
    end
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_gestures();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/tts_pkg.sv
src/tts_cfg_regs.sv
src/tts_classify.sv
src/touch_tap_swipe_classifier.sv
sim/touch_tap_swipe_classifier_tb.sv
